/* rtl/nq_pkg.sv */
// ----------------------------------------------------------------------------
// nq_pkg: shared types and constants of the MIDI note quantizer
// Field widths, event and error codes, and the channel payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package nq_pkg;

	localparam int TICK_W = 28;
	localparam int KEY_W  = 7;
	localparam int STEP_W = 5;   // holds TICK_W - 1

	localparam logic [TICK_W-1:0] TICK_MAX      = 28'hFFFFFFF;
	localparam logic [TICK_W-1:0] QUANTUM_RESET = 28'd120;

	// input command
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_END   = 1'b1;

	// event kinds (kind 3 behaves as other)
	localparam logic [1:0] KIND_OTHER    = 2'd0;
	localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_FULL     = 2'd2;

	typedef struct packed {
		logic              command;
		logic [TICK_W-1:0] delta_tick;
		logic [1:0]        event_kind;
		logic [KEY_W-1:0]  key_number;
	} event_t;

	typedef struct packed {
		logic              is_note_on;
		logic [KEY_W-1:0]  out_key;
		logic [TICK_W-1:0] out_tick;
		logic [1:0]        error_code;
		logic              last_of_run;
	} note_t;

endpackage

`default_nettype wire

/* rtl/nq_ram.sv */
// ----------------------------------------------------------------------------
// nq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/nq_rem.sv */
// ----------------------------------------------------------------------------
// nq_rem: iterative remainder unit
// Restoring division, one quotient bit per cycle; gives tick % divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module nq_rem (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [nq_pkg::TICK_W-1:0] dividend,
	input  wire logic [nq_pkg::TICK_W-1:0] divisor,
	output logic                          done,
	output logic      [nq_pkg::TICK_W-1:0] remainder
);

	import nq_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TICK_W-1:0] dvd_q;
	logic [TICK_W-1:0] dvs_q;
	logic [TICK_W-1:0] rem_q;
	logic [TICK_W:0]   trial;
	logic [TICK_W:0]   diff;

	// shared compare/subtract of one step
	assign trial = {rem_q, dvd_q[TICK_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// done pulses once, after the last step
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(TICK_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			if (!diff[TICK_W]) begin
				rem_q <= diff[TICK_W-1:0];
			end else begin
				rem_q <= trial[TICK_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* rtl/midi_note_quantizer.sv */
// ----------------------------------------------------------------------------
// midi_note_quantizer: note time quantizer for one MIDI track
// Rounds note times to the quantum grid, groups note-ons into chords and
// releases each chord when the next one starts or at end of track.
// ----------------------------------------------------------------------------
// Usage:
//   event channel (event_valid / event_stall / event_data) takes one track
//   event or an end-of-track command. A transfer happens when valid is high
//   and stall is low. event_stall stays high while an item is in work.
//   note channel (note_valid / note_stall / note_data) gives the results of
//   the item in order; last_of_run marks the final one.
//   quantum_we / quantum_wdata write the grid spacing (reset 120); write it
//   only while the block is idle.
// Sequencing:
//   Note events use the shared remainder unit, one bit per cycle; other
//   events skip it. No new transfer is taken until the current item is
//   through.
//   Each released chord key takes one RAM read and one output transfer.
// Reset clears the tick state, chord count and error flag; the chord key
// RAM needs no clearing. A stalled receiver holds the result register and
// the sequencer waits; no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_quantizer #(
	parameter int CHORD_MAX = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      event_valid,
	output logic                           event_stall,
	input  wire nq_pkg::event_t            event_data,
	output logic                           note_valid,
	input  wire logic                      note_stall,
	output nq_pkg::note_t                  note_data,
	input  wire logic                      quantum_we,
	input  wire logic [nq_pkg::TICK_W-1:0] quantum_wdata
);

	import nq_pkg::*;

	localparam int CNT_W = $clog2(CHORD_MAX + 1);
	localparam int IDX_W = (CHORD_MAX > 1) ? $clog2(CHORD_MAX) : 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DISPATCH  = 3'd1;
	localparam logic [2:0] ST_DIV       = 3'd2;
	localparam logic [2:0] ST_ROUND     = 3'd3;
	localparam logic [2:0] ST_NOTE_ON   = 3'd4;
	localparam logic [2:0] ST_FLUSH_RD  = 3'd5;
	localparam logic [2:0] ST_FLUSH_OUT = 3'd6;
	localparam logic [2:0] ST_ERR       = 3'd7;

	logic [2:0]        state_q;
	logic [TICK_W-1:0] quantum_q;
	logic [TICK_W-1:0] abs_q;
	logic [TICK_W-1:0] release_q;
	logic [TICK_W-1:0] chord_tick_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              err_q;
	event_t            item_q;
	logic [TICK_W-1:0] qt_q;
	logic [TICK_W-1:0] flush_tick_q;
	logic [IDX_W-1:0]  idx_q;
	logic              end_q;
	logic [1:0]        code_q;
	logic [TICK_W-1:0] base_q;
	logic              up_q;
	logic              note_valid_q;
	note_t             note_q;

	logic              accept;
	logic              emit_ok;
	logic              emit;
	logic [TICK_W-1:0] q_eff;
	logic [TICK_W:0]   sum;
	logic [TICK_W:0]   rel_bump;
	logic [TICK_W:0]   rounded;
	logic              last_key;
	logic              rem_start;
	logic              rem_done;
	logic [TICK_W-1:0] rem_val;
	logic [KEY_W-1:0]  key_rd;
	logic              key_we;

	assign accept      = event_valid && !event_stall;
	assign event_stall = (state_q != ST_IDLE);
	assign emit_ok     = !note_valid_q || !note_stall;
	assign emit        = emit_ok && ((state_q == ST_NOTE_ON) || (state_q == ST_FLUSH_OUT) ||
	                                 (state_q == ST_ERR));
	assign q_eff       = (quantum_q == '0) ? TICK_W'(1) : quantum_q;
	assign sum         = {1'b0, abs_q} + {1'b0, item_q.delta_tick};
	assign rel_bump    = {1'b0, release_q} + {1'b0, quantum_q};
	assign rounded     = {1'b0, base_q} + (up_q ? {1'b0, q_eff} : '0);
	assign last_key    = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
	assign rem_start   = (state_q == ST_DISPATCH) && (item_q.command == CMD_EVENT) &&
	                     !err_q && !sum[TICK_W] &&
	                     ((item_q.event_kind == KIND_NOTE_ON) ||
	                      (item_q.event_kind == KIND_NOTE_OFF));
	assign key_we      = (state_q == ST_NOTE_ON) && emit_ok;

	// shared remainder unit
	nq_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (sum[TICK_W-1:0]),
		.divisor   (q_eff),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// chord key store
	nq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CHORD_MAX)
	) u_keys (
		.clk   (clk),
		.we    (key_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (item_q.key_number),
		.raddr (idx_q),
		.rdata (key_rd)
	);

	// quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (quantum_we) begin
			quantum_q <= quantum_wdata;
		end
	end

	// result valid flag: set on a new result, cleared on its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_valid_q <= 1'b0;
		end else if (emit) begin
			note_valid_q <= 1'b1;
		end else if (!note_stall) begin
			note_valid_q <= 1'b0;
		end
	end

	// sequencer and track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			abs_q        <= '0;
			release_q    <= '0;
			chord_tick_q <= '0;
			cnt_q        <= '0;
			err_q        <= 1'b0;
			qt_q         <= '0;
			flush_tick_q <= '0;
			idx_q        <= '0;
			end_q        <= 1'b0;
			code_q       <= ERR_NONE;
			base_q       <= '0;
			up_q         <= 1'b0;
			note_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (item_q.command == CMD_END) begin
						if (!err_q && cnt_q != '0) begin
							end_q <= 1'b1;
							if (chord_tick_q >= release_q) begin
								if (rel_bump[TICK_W]) begin
									code_q  <= ERR_OVERFLOW;
									state_q <= ST_ERR;
								end else begin
									flush_tick_q <= rel_bump[TICK_W-1:0];
									idx_q        <= '0;
									state_q      <= ST_FLUSH_RD;
								end
							end else begin
								flush_tick_q <= release_q;
								idx_q        <= '0;
								state_q      <= ST_FLUSH_RD;
							end
						end else begin
							abs_q        <= '0;
							release_q    <= '0;
							chord_tick_q <= '0;
							cnt_q        <= '0;
							err_q        <= 1'b0;
							state_q      <= ST_IDLE;
						end
					end else if (err_q) begin
						state_q <= ST_IDLE;
					end else if (sum[TICK_W]) begin
						end_q   <= 1'b0;
						code_q  <= ERR_OVERFLOW;
						state_q <= ST_ERR;
					end else begin
						abs_q   <= sum[TICK_W-1:0];
						end_q   <= 1'b0;
						state_q <= rem_start ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: begin
					// tick minus remainder, and the half-way test
					if (rem_done) begin
						base_q  <= abs_q - rem_val;
						up_q    <= ({rem_val, 1'b0} >= {1'b0, q_eff});
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (rounded[TICK_W]) begin
						code_q  <= ERR_OVERFLOW;
						state_q <= ST_ERR;
					end else if (item_q.event_kind == KIND_NOTE_OFF) begin
						release_q <= rounded[TICK_W-1:0];
						state_q   <= ST_IDLE;
					end else begin
						qt_q <= rounded[TICK_W-1:0];
						if (cnt_q != '0 && chord_tick_q != rounded[TICK_W-1:0]) begin
							flush_tick_q <= rounded[TICK_W-1:0];
							idx_q        <= '0;
							state_q      <= ST_FLUSH_RD;
						end else if (cnt_q >= CNT_W'(CHORD_MAX)) begin
							code_q  <= ERR_FULL;
							state_q <= ST_ERR;
						end else begin
							state_q <= ST_NOTE_ON;
						end
					end
				end
				ST_NOTE_ON: begin
					if (emit_ok) begin
						note_q       <= '{is_note_on: 1'b1, out_key: item_q.key_number,
						                  out_tick: qt_q, error_code: ERR_NONE,
						                  last_of_run: 1'b1};
						cnt_q        <= cnt_q + 1'b1;
						chord_tick_q <= qt_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_FLUSH_RD: begin
					// RAM read of the current key
					state_q <= ST_FLUSH_OUT;
				end
				ST_FLUSH_OUT: begin
					if (emit_ok) begin
						note_q       <= '{is_note_on: 1'b0, out_key: key_rd,
						                  out_tick: flush_tick_q, error_code: ERR_NONE,
						                  last_of_run: last_key && end_q};
						if (last_key) begin
							cnt_q <= '0;
							if (end_q) begin
								abs_q        <= '0;
								release_q    <= '0;
								chord_tick_q <= '0;
								err_q        <= 1'b0;
								state_q      <= ST_IDLE;
							end else begin
								state_q <= ST_NOTE_ON;
							end
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_FLUSH_RD;
						end
					end
				end
				ST_ERR: begin
					if (emit_ok) begin
						note_q       <= '{is_note_on: 1'b0, out_key: '0, out_tick: '0,
						                  error_code: code_q, last_of_run: 1'b1};
						if (end_q) begin
							abs_q        <= '0;
							release_q    <= '0;
							chord_tick_q <= '0;
							cnt_q        <= '0;
							err_q        <= 1'b0;
						end else begin
							err_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= event_data;
		end
	end

	assign note_valid = note_valid_q;
	assign note_data  = note_q;

`ifndef SYNTHESIS
	// a new item is held off right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> event_stall)
		else $error("event channel not stalled after transfer");

	// chord count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CHORD_MAX))
		else $error("chord count beyond store depth");

	// error results carry no note and end the run
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(note_valid && note_data.error_code != ERR_NONE) |->
		(note_data.last_of_run && !note_data.is_note_on && note_data.out_key == '0))
		else $error("malformed error result");

	// a note-on is always the final result of its item
	a_note_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(note_valid && note_data.is_note_on) |-> note_data.last_of_run)
		else $error("note-on not marked last");

	// the remainder unit finishes only while the sequencer waits for it
	a_rem_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_DIV))
		else $error("remainder done outside divide state");
`endif

endmodule

`default_nettype wire
